### rtl/cbt_pkg.sv
`default_nettype none

package cbt_pkg;

  // Field widths, fixed by the register and the channel payloads.
  localparam int unsigned ClockW  = 29;
  localparam int unsigned RateW   = 20;
  localparam int unsigned PerBitW = 20;
  localparam int unsigned PrescW  = 11;
  localparam int unsigned Seg1W   = 4;
  localparam int unsigned Seg2W   = 3;
  localparam int unsigned QW      = 5;

  localparam logic [ClockW-1:0] ClockReset = 29'd42000000;
  localparam logic [RateW-1:0]  MinRate    = 20'd1000;
  localparam logic [RateW-1:0]  FastRate   = 20'd1000000;
  localparam logic [QW-1:0]     MaxQFast   = 5'd10;
  localparam logic [QW-1:0]     MaxQSlow   = 5'd17;
  localparam logic [QW-1:0]     MinQ       = 5'd3;
  localparam logic [ClockW-1:0] MaxPresc   = 29'd1024;

  // A sample point above 900 permille is the same as 1000 * a >= 901 * b.
  localparam logic [15:0] SpScale = 16'd1000;
  localparam logic [15:0] SpLimit = 16'd901;

  typedef struct packed {
    logic             ok;
    logic [Seg1W-1:0] seg1_code;
    logic [Seg2W-1:0] seg2_code;
  } seg_t;

  typedef struct packed {
    logic              done;
    logic [ClockW-1:0] quotient;
    logic [RateW-1:0]  remainder;
  } div_rsp_t;

  // Segment split for a bit of (sum + 1) quanta; depends on the quanta count only.
  function automatic seg_t seg_lookup(input logic [QW-1:0] sum);
    logic [7:0]  sum8;
    logic [7:0]  s1_near;
    logic [7:0]  s1;
    logic [7:0]  s2;
    logic [15:0] lhs;
    logic [15:0] rhs;
    logic        room;
    seg_t        r;
    sum8    = {3'b000, sum};
    s1_near = (8'd7 * sum8 + 8'd3) >> 3;
    room    = sum8 > s1_near;
    lhs     = SpScale * (16'd1 + {8'h00, s1_near});
    rhs     = SpLimit * (16'd1 + {8'h00, sum8});
    if (lhs >= rhs) begin
      s1 = (8'd7 * sum8 - 8'd1) >> 3;
    end else begin
      s1 = s1_near;
    end
    s2          = sum8 - s1;
    r.ok        = room && (s1 >= 8'd1) && (s1 <= 8'd16) && (s2 >= 8'd1) && (s2 <= 8'd8);
    r.seg1_code = Seg1W'(s1 - 8'd1);
    r.seg2_code = Seg2W'(s2 - 8'd1);
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/cbt_if.sv
`default_nettype none

interface cbt_in_if;
  logic                      valid;
  logic                      ready;
  logic [cbt_pkg::RateW-1:0] bit_rate;

  modport source (output valid, output bit_rate, input ready);
  modport sink   (input valid, input bit_rate, output ready);
endinterface

interface cbt_out_if;
  logic                       valid;
  logic                       ready;
  logic                       failed;
  logic [cbt_pkg::PrescW-1:0] prescaler;
  logic [cbt_pkg::Seg1W-1:0]  seg1_code;
  logic [cbt_pkg::Seg2W-1:0]  seg2_code;

  modport source (output valid, output failed, output prescaler, output seg1_code,
                  output seg2_code, input ready);
  modport sink   (input valid, input failed, input prescaler, input seg1_code,
                  input seg2_code, output ready);
endinterface

`default_nettype wire

### rtl/cbt_div.sv
`default_nettype none

// Restoring radix-2 divider, one quotient bit per cycle.
module cbt_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [cbt_pkg::ClockW-1:0] dividend_i,
  input  logic [cbt_pkg::RateW-1:0]  divisor_i,
  output cbt_pkg::div_rsp_t          rsp_o
);
  import cbt_pkg::*;

  localparam int unsigned CntW = $clog2(ClockW);
  localparam logic [CntW-1:0] CntLast = CntW'(ClockW - 1);

  logic              busy_q;
  logic              done_q;
  logic [CntW-1:0]   cnt_q;
  logic [ClockW-1:0] quo_q;
  logic [RateW-1:0]  rem_q;
  logic [RateW-1:0]  dvs_q;

  logic [RateW:0]    partial;
  logic [RateW:0]    diff;
  logic              ge;
  logic [RateW-1:0]  rem_next;

  assign partial  = {rem_q, quo_q[ClockW-1]};
  assign diff     = partial - {1'b0, dvs_q};
  assign ge       = partial >= {1'b0, dvs_q};
  assign rem_next = ge ? diff[RateW-1:0] : partial[RateW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CntW'(1);
      if (cnt_q == CntLast) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[ClockW-2:0], ge};
      rem_q <= rem_next;
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

`default_nettype wire

### rtl/can_bit_timing_calculator_top.sv
`default_nettype none

// Channel   Direction  Handshake      Payload
// cfg       in         cfg_we_i       cfg_wdata_i: peripheral clock in Hz (29 bits)
// in_i      in         valid/ready    bit_rate (20 bits)
// out_o     out        valid/ready    failed, prescaler, seg1_code, seg2_code
//
// One beat is worked on at a time; in_i.ready is low from acceptance until the
// result has been moved into the output register.
// Each division on the shared radix-2 divider is a load and 29 steps; the cycle
// that sees one division done loads the next. A beat needs one division of the
// clock by the rate plus one division of the per-bit count for every quanta
// count tried (up to 15); a rate below 1000 fails without using the divider.
// Reset clears the control state and loads the clock register with 42 MHz.
// A stalled output holds its beat while the next input beat is taken and worked on.

module can_bit_timing_calculator_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [cbt_pkg::ClockW-1:0] cfg_wdata_i,
  cbt_in_if.sink                     in_i,
  cbt_out_if.source                  out_o
);
  import cbt_pkg::*;

  localparam logic [1:0] StIdle    = 2'd0;
  localparam logic [1:0] StDivRate = 2'd1;
  localparam logic [1:0] StDivQ    = 2'd2;
  localparam logic [1:0] StDone    = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [ClockW-1:0]  clock_q;
  logic [QW-1:0]      q_q, q_d;
  logic [PerBitW-1:0] per_bit_q, per_bit_d;
  logic               exact_q, exact_d;

  // Result of the current beat, waiting for the output register.
  logic               res_fail_q, res_fail_d;
  logic [PrescW-1:0]  res_presc_q, res_presc_d;
  logic [Seg1W-1:0]   res_seg1_q, res_seg1_d;
  logic [Seg2W-1:0]   res_seg2_q, res_seg2_d;

  logic               out_valid_q, out_valid_d;
  logic               out_load;
  logic               out_failed_q;
  logic [PrescW-1:0]  out_presc_q;
  logic [Seg1W-1:0]   out_seg1_q;
  logic [Seg2W-1:0]   out_seg2_q;

  logic               div_start;
  logic [ClockW-1:0]  div_dividend;
  logic [RateW-1:0]   div_divisor;
  div_rsp_t           div_rsp;

  logic [QW-1:0]      q_dec;
  seg_t               seg;
  logic               presc_ok;

  cbt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .rsp_o      (div_rsp)
  );

  assign q_dec    = q_q - QW'(1);
  assign seg      = seg_lookup(q_dec);
  assign presc_ok = (div_rsp.quotient != '0) && (div_rsp.quotient <= MaxPresc);

  assign in_i.ready = (state_q == StIdle);

  always_comb begin
    state_d      = state_q;
    q_d          = q_q;
    per_bit_d    = per_bit_q;
    exact_d      = exact_q;
    res_fail_d   = res_fail_q;
    res_presc_d  = res_presc_q;
    res_seg1_d   = res_seg1_q;
    res_seg2_d   = res_seg2_q;
    out_load     = 1'b0;
    div_start    = 1'b0;
    div_dividend = clock_q;
    div_divisor  = in_i.bit_rate;

    case (state_q)
      StIdle: begin
        if (in_i.valid) begin
          if (in_i.bit_rate < MinRate) begin
            res_fail_d  = 1'b1;
            res_presc_d = '0;
            res_seg1_d  = '0;
            res_seg2_d  = '0;
            state_d     = StDone;
          end else begin
            div_start = 1'b1;
            q_d       = (in_i.bit_rate >= FastRate) ? MaxQFast : MaxQSlow;
            state_d   = StDivRate;
          end
        end
      end
      StDivRate: begin
        // The rate is met exactly when clock / per_bit gives the rate back,
        // which holds when the remainder stays below the per-bit count.
        div_dividend = div_rsp.quotient;
        div_divisor  = {{(RateW - QW){1'b0}}, q_q};
        if (div_rsp.done) begin
          per_bit_d = div_rsp.quotient[PerBitW-1:0];
          exact_d   = {{(ClockW - RateW){1'b0}}, div_rsp.remainder} < div_rsp.quotient;
          div_start = 1'b1;
          state_d   = StDivQ;
        end
      end
      StDivQ: begin
        div_dividend = {{(ClockW - PerBitW){1'b0}}, per_bit_q};
        div_divisor  = {{(RateW - QW){1'b0}}, q_dec};
        if (div_rsp.done) begin
          if (div_rsp.remainder == '0) begin
            state_d = StDone;
            if (presc_ok && seg.ok && exact_q) begin
              res_fail_d  = 1'b0;
              res_presc_d = div_rsp.quotient[PrescW-1:0];
              res_seg1_d  = seg.seg1_code;
              res_seg2_d  = seg.seg2_code;
            end else begin
              res_fail_d  = 1'b1;
              res_presc_d = '0;
              res_seg1_d  = '0;
              res_seg2_d  = '0;
            end
          end else if (q_q <= MinQ) begin
            res_fail_d  = 1'b1;
            res_presc_d = '0;
            res_seg1_d  = '0;
            res_seg2_d  = '0;
            state_d     = StDone;
          end else begin
            // Try the next smaller quanta count.
            q_d       = q_dec;
            div_start = 1'b1;
          end
        end
      end
      StDone: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    out_valid_d = out_load || (out_valid_q && !out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      clock_q     <= ClockReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        clock_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    q_q         <= q_d;
    per_bit_q   <= per_bit_d;
    exact_q     <= exact_d;
    res_fail_q  <= res_fail_d;
    res_presc_q <= res_presc_d;
    res_seg1_q  <= res_seg1_d;
    res_seg2_q  <= res_seg2_d;
    if (out_load) begin
      out_failed_q <= res_fail_q;
      out_presc_q  <= res_presc_q;
      out_seg1_q   <= res_seg1_q;
      out_seg2_q   <= res_seg2_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.failed    = out_failed_q;
  assign out_o.prescaler = out_presc_q;
  assign out_o.seg1_code = out_seg1_q;
  assign out_o.seg2_code = out_seg2_q;

endmodule

`default_nettype wire

### rtl/cbt_checker.sv
`default_nettype none

module cbt_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic                       out_failed_i,
  input logic [cbt_pkg::PrescW-1:0] out_prescaler_i,
  input logic [cbt_pkg::Seg1W-1:0]  out_seg1_code_i,
  input logic [cbt_pkg::Seg2W-1:0]  out_seg2_code_i
);
  import cbt_pkg::*;

  // An accepted beat moves the block out of idle, so the input closes after acceptance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input ready right after an accepted beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_failed_i) |->
      (out_prescaler_i == '0) && (out_seg1_code_i == '0) && (out_seg2_code_i == '0))
    else $error("failed result carries nonzero fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_failed_i) |->
      (out_prescaler_i != '0) && (out_prescaler_i <= PrescW'(1024)))
    else $error("prescaler out of range on a good result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("output beat dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      $stable(out_failed_i) && $stable(out_prescaler_i) &&
      $stable(out_seg1_code_i) && $stable(out_seg2_code_i))
    else $error("output payload changed while stalled");

endmodule

bind can_bit_timing_calculator_top cbt_checker u_cbt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_failed_i    (out_o.failed),
  .out_prescaler_i (out_o.prescaler),
  .out_seg1_code_i (out_o.seg1_code),
  .out_seg2_code_i (out_o.seg2_code)
);

`default_nettype wire

### test/can_bit_timing_calculator_top_tb.sv
`default_nettype none

// Testbench for the CAN bit timing calculator.
// A driver feeds requested bit rates into the input channel from a queue.
// A monitor takes results from the output channel and checks each one against
// a local model of the timing search. The run goes through several clock
// settings and several patterns of sender gaps and receiver back-pressure.
module can_bit_timing_calculator_top_tb;
  import cbt_pkg::*;

  // Limits of the timing search that the package does not name.
  localparam int unsigned MaxSamplePermille = 900;
  localparam int unsigned MaxSeg1           = 16;
  localparam int unsigned MaxSeg2           = 8;

  // Run shape.
  localparam int unsigned NumPhases           = 9;
  localparam int unsigned RandomBeatsPerPhase = 82;
  localparam int unsigned DrainCycles         = 600;
  localparam int unsigned SettleCycles        = 4;

  // One expected or observed result.
  typedef struct packed {
    logic              failed;
    logic [PrescW-1:0] prescaler;
    logic [Seg1W-1:0]  seg1_code;
    logic [Seg2W-1:0]  seg2_code;
  } timing_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [ClockW-1:0] cfg_wdata_i;

  cbt_in_if  in_if ();
  cbt_out_if out_if ();

  can_bit_timing_calculator_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Bit rates still to be offered, and the timings that accepted beats must produce.
  logic [RateW-1:0] rate_queue [$];
  timing_t          expected_timing [$];

  // Local copy of the clock register; it starts at the reset value of the block.
  logic [ClockW-1:0] clock_setting = ClockReset;

  // Percentages of cycles in which the sender holds back and the receiver stalls.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;

  int unsigned mismatch_count      = 0;
  int unsigned beats_checked       = 0;
  int unsigned timings_found       = 0;
  int unsigned clock_settings_used = 1;

  // Bit rates that real CAN networks use; many random beats are drawn from them.
  int unsigned common_rates [10] = '{10000, 20000, 50000, 83333, 100000,
                                     125000, 250000, 500000, 800000, 1000000};

  // The opening beats cover the field extremes and each way the search can end:
  // rates below the minimum (zero among them), the boundaries at 1000 and at
  // 1 Mbit/s, a per-bit count with no usable divisor (41625 gives the prime 1009),
  // a prescaler above 1024 (1000 at 42 MHz), a rate that is not met exactly,
  // and a quanta count of 11 whose nearest sample point lies above 900 permille,
  // so segment one has to be rounded down (381818).
  logic [RateW-1:0] directed_rates [20] = '{
    20'd0, 20'd1, 20'd999, 20'd1000, 20'd1001, 20'd10000, 20'd41625, 20'd50000,
    20'd83333, 20'd125000, 20'd250000, 20'd381818, 20'd500000, 20'd800000,
    20'd999999, 20'd1000000, 20'hFFFFF, 20'h55555, 20'hAAAAA, 20'd13712
  };

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Model of the timing search. The quanta count per bit runs from its maximum
  // down to 3 and stops at the first one that divides clock / rate. Every way
  // out other than a full success gives the all-zero failure result.
  function automatic timing_t predict_timing(input logic [RateW-1:0]  rate,
                                             input logic [ClockW-1:0] clk_hz);
    int unsigned r;
    int unsigned c;
    int unsigned per_bit;
    int unsigned quanta;
    int unsigned presc;
    int unsigned seg1;
    int unsigned seg2;
    int unsigned permille;
    timing_t     t;
    t        = '0;
    t.failed = 1'b1;
    r        = 32'(rate);
    c        = 32'(clk_hz);
    if (r < MinRate) begin
      return t;
    end
    per_bit = c / r;
    quanta  = 32'((r >= FastRate) ? MaxQFast : MaxQSlow);
    while (per_bit % quanta != 0) begin
      if (quanta <= MinQ) begin
        return t;
      end
      quanta--;
    end
    presc = per_bit / quanta;
    if (presc < 1 || presc > MaxPresc) begin
      return t;
    end
    // Segment one first aims at a 7/8 sample point, rounded to nearest.
    seg1 = (7 * (quanta - 1) + 3) / 8;
    if (quanta - 1 <= seg1) begin
      return t;
    end
    permille = (1000 * (1 + seg1)) / quanta;
    if (permille > MaxSamplePermille) begin
      seg1 = (7 * (quanta - 1) - 1) / 8;
    end
    seg2 = quanta - 1 - seg1;
    if (seg1 < 1 || seg1 > MaxSeg1 || seg2 < 1 || seg2 > MaxSeg2) begin
      return t;
    end
    if (r != c / (presc * quanta)) begin
      return t;
    end
    t.failed    = 1'b0;
    t.prescaler = PrescW'(presc);
    t.seg1_code = Seg1W'(seg1 - 1);
    t.seg2_code = Seg2W'(seg2 - 1);
    return t;
  endfunction

  // Random rate for the current clock. Most rates are common bus rates or rates
  // derived from the clock for a chosen prescaler and quanta count, so that
  // the search gets deep; the rest probe both rate boundaries or are noise.
  function automatic logic [RateW-1:0] random_rate();
    int unsigned pick;
    int unsigned quanta;
    int unsigned presc;
    int unsigned r;
    pick = $urandom_range(99);
    if (pick < 35) begin
      return RateW'(common_rates[$urandom_range(9)]);
    end else if (pick < 65) begin
      quanta = $urandom_range(3, 17);
      presc  = ($urandom_range(3) == 0) ? $urandom_range(1, 1024) : $urandom_range(1, 64);
      r      = clock_setting / (presc * quanta);
      if (r >= MinRate && r <= 20'hFFFFF) begin
        return RateW'(r);
      end
      return RateW'(common_rates[$urandom_range(9)]);
    end else if (pick < 75) begin
      return RateW'($urandom_range(0, 1100));
    end else if (pick < 85) begin
      return RateW'($urandom_range(990000, 20'hFFFFF));
    end
    return RateW'($urandom());
  endfunction

  // Clock used in each phase. Phase 0 keeps the reset value; the others cover
  // zero, the largest value, common crystal rates and one random value.
  function automatic logic [ClockW-1:0] phase_clock(input int unsigned phase);
    case (phase)
      1: begin
        return 29'd8000000;
      end
      2: begin
        return 29'd0;
      end
      3: begin
        return {ClockW{1'b1}};
      end
      4: begin
        return 29'd16000000;
      end
      5: begin
        return 29'd80000000;
      end
      6: begin
        return 29'd24000000;
      end
      7: begin
        return ClockW'($urandom());
      end
      default: begin
        return 29'd48000000;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Returns at a falling edge once nothing is queued, offered or outstanding.
  task automatic wait_idle();
    while (rate_queue.size() != 0 || in_if.valid || expected_timing.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // The register takes the value at the edge where the write enable is high.
  task automatic write_clock(input logic [ClockW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    clock_setting  = value;
    clock_settings_used++;
  endtask

  // Driver. A beat that is offered stays on the channel until it is taken; the
  // sender may only hold back between beats. The expected timing is worked out
  // at the edge of acceptance, with the clock setting in force at that moment.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_timing.push_back(predict_timing(in_if.bit_rate, clock_setting));
      end
      if (!in_if.valid || in_if.ready) begin
        if (rate_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_if.valid    <= 1'b1;
          in_if.bit_rate <= rate_queue.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Each beat taken from the output is compared field by field with
  // the oldest expected timing. Ready is drawn afresh every cycle.
  always @(posedge clk_i) begin : monitor_b
    timing_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_timing.size() == 0) begin
          report_mismatch($sformatf("result with none expected: failed=%0d prescaler=%0d",
                                    out_if.failed, out_if.prescaler));
        end else begin
          want = expected_timing.pop_front();
          beats_checked++;
          if (!want.failed) begin
            timings_found++;
          end
          if (out_if.failed !== want.failed) begin
            report_mismatch($sformatf("failed: want %0d got %0d", want.failed, out_if.failed));
          end
          if (out_if.prescaler !== want.prescaler) begin
            report_mismatch($sformatf("prescaler: want %0d got %0d",
                                      want.prescaler, out_if.prescaler));
          end
          if (out_if.seg1_code !== want.seg1_code) begin
            report_mismatch($sformatf("seg1_code: want %0d got %0d",
                                      want.seg1_code, out_if.seg1_code));
          end
          if (out_if.seg2_code !== want.seg2_code) begin
            report_mismatch($sformatf("seg2_code: want %0d got %0d",
                                      want.seg2_code, out_if.seg2_code));
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Stimulus. Each phase starts from an idle block, sets the clock (all but phase 0),
  // picks an idling pattern and queues its beats. The patterns rotate: no idling, a
  // sender idle 60 percent of the time, a receiver stalling 60 percent of the
  // time, and both at 21 percent.
  initial begin : stimulus
    int unsigned phase;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_if.valid    = 1'b0;
    in_if.bit_rate = '0;
    out_if.ready   = 1'b0;
    rst_ni         = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (phase = 0; phase < NumPhases; phase++) begin
      wait_idle();
      repeat (SettleCycles) @(posedge clk_i);
      if (phase != 0) begin
        write_clock(phase_clock(phase));
      end
      @(negedge clk_i);
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 60;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 60;
        end
        default: begin
          send_idle_pct = 21;
          stall_pct     = 21;
        end
      endcase
      if (phase == 0) begin
        foreach (directed_rates[i]) begin
          rate_queue.push_back(directed_rates[i]);
        end
      end
      repeat (RandomBeatsPerPhase) rate_queue.push_back(random_rate());
    end

    // Let any stray result show up before the verdict.
    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Checked %0d beats under %0d clock settings: %0d timings found, %0d rejected.",
             beats_checked, clock_settings_used, timings_found,
             beats_checked - timings_found);
    if (mismatch_count == 0) begin
      $display("can_bit_timing_calculator_top_tb: PASS");
    end else begin
      $display("%0d mismatches.", mismatch_count);
      $display("can_bit_timing_calculator_top_tb: FAIL");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a tenth of this time.
  initial begin
    #40000000;
    $display("Timeout with %0d beats still expected.", expected_timing.size());
    $display("can_bit_timing_calculator_top_tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
